// ===== rtl/query_operator_lexer_defines.svh =====
// assertion macros for the query operator lexer
// used by the top level; expects i_clk and i_rst_n in scope
`ifndef QUERY_OPERATOR_LEXER_DEFINES_SVH
`define QUERY_OPERATOR_LEXER_DEFINES_SVH

// same-cycle implication, off while in reset
`define QOL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define QOL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/qol_pkg.sv =====
// shared types, token codes and character helpers for the query operator lexer
// no dependencies
package qol_pkg;

    localparam int unsigned QDepth = 4;
    localparam int unsigned QPtrW  = $clog2(QDepth);

    localparam logic [4:0] TK_IDENT  = 5'd0;
    localparam logic [4:0] TK_LPAREN = 5'd1;
    localparam logic [4:0] TK_RPAREN = 5'd2;
    localparam logic [4:0] TK_LT     = 5'd3;
    localparam logic [4:0] TK_LE     = 5'd4;
    localparam logic [4:0] TK_ARROW  = 5'd5;
    localparam logic [4:0] TK_GT     = 5'd6;
    localparam logic [4:0] TK_GE     = 5'd7;
    localparam logic [4:0] TK_PLUS   = 5'd8;
    localparam logic [4:0] TK_MINUS  = 5'd9;
    localparam logic [4:0] TK_STAR   = 5'd10;
    localparam logic [4:0] TK_COMMA  = 5'd11;
    localparam logic [4:0] TK_SEMI   = 5'd12;
    localparam logic [4:0] TK_EQ     = 5'd13;
    localparam logic [4:0] TK_EQEQ   = 5'd14;
    localparam logic [4:0] TK_OROR   = 5'd15;
    localparam logic [4:0] TK_ANDAND = 5'd16;
    localparam logic [4:0] TK_QUOTE  = 5'd17;
    localparam logic [4:0] TK_ERROR  = 5'd18;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_EOT  = 1'b1;

    localparam logic [7:0] CH_UNDER = 8'h5f;
    localparam logic [7:0] CH_LT    = 8'h3c;
    localparam logic [7:0] CH_GT    = 8'h3e;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_BAR   = 8'h7c;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_SEMI  = 8'h3b;

    typedef enum logic [2:0] {
        PEND_NONE = 3'd0,
        PEND_LT   = 3'd1,
        PEND_GT   = 3'd2,
        PEND_EQ   = 3'd3,
        PEND_OR   = 3'd4,
        PEND_AND  = 3'd5
    } t_pend;

    typedef struct packed {
        logic       kind;
        logic [7:0] text_byte;
    } t_in;

    typedef struct packed {
        logic [4:0] token_kind;
        logic [7:0] ident_char;
        logic       token_end;
        logic       run_last;
    } t_out;

    // one queue entry: the results of one input byte
    typedef struct packed {
        t_out res0;
        t_out res1;
        logic two;
    } t_entry;

    function automatic logic is_ident(input logic [7:0] b);
        return (b inside {[8'h61:8'h7a], [8'h41:8'h5a], [8'h30:8'h39]}) || (b == CH_UNDER);
    endfunction

    function automatic logic is_single(input logic [7:0] b);
        return b inside {CH_LPAR, CH_RPAR, CH_PLUS, CH_MINUS, CH_STAR, CH_COMMA,
                         CH_SEMI, CH_QUOTE};
    endfunction

    function automatic logic [4:0] single_kind(input logic [7:0] b);
        logic [4:0] k;
        case (b)
            CH_LPAR:  k = TK_LPAREN;
            CH_RPAR:  k = TK_RPAREN;
            CH_PLUS:  k = TK_PLUS;
            CH_MINUS: k = TK_MINUS;
            CH_STAR:  k = TK_STAR;
            CH_COMMA: k = TK_COMMA;
            CH_SEMI:  k = TK_SEMI;
            CH_QUOTE: k = TK_QUOTE;
            default:  k = TK_ERROR;
        endcase
        return k;
    endfunction

    function automatic t_pend pend_code(input logic [7:0] b);
        t_pend p;
        case (b)
            CH_LT:   p = PEND_LT;
            CH_GT:   p = PEND_GT;
            CH_EQ:   p = PEND_EQ;
            CH_BAR:  p = PEND_OR;
            CH_AMP:  p = PEND_AND;
            default: p = PEND_NONE;
        endcase
        return p;
    endfunction

    function automatic t_out mk(input logic [4:0] k, input logic [7:0] c, input logic e);
        t_out r;
        r.token_kind = k;
        r.ident_char = c;
        r.token_end  = e;
        r.run_last   = 1'b0;
        return r;
    endfunction

endpackage

// ===== rtl/qol_front.sv =====
// front end: takes one byte per cycle while i_accept is high, tracks lexer state, forms up to two results
// depends on qol_pkg
module qol_front import qol_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_accept,
    input  t_in    i_in,
    output logic   o_push,
    output t_entry o_entry
);

    logic [7:0] r_held, n_held;
    logic       r_hv, n_hv;
    t_pend      r_pend, n_pend;
    logic       r_err, n_err;

    logic [1:0] cnt;
    t_out       res0, res1;
    logic [7:0] b;
    logic       b_id, b_single;
    logic [4:0] pair;

    assign b        = i_in.text_byte;
    assign b_id     = is_ident(b);
    assign b_single = is_single(b);

    always_comb begin
        n_held = r_held;
        n_hv   = r_hv;
        n_pend = r_pend;
        n_err  = r_err;
        cnt    = 2'd0;
        res0   = '0;
        res1   = '0;
        pair   = TK_IDENT;

        if (i_in.kind == KIND_EOT) begin
            if (!r_err) begin
                if (r_hv) begin
                    res0 = mk(TK_IDENT, r_held, 1'b1);
                    cnt  = 2'd1;
                end else begin
                    case (r_pend)
                        PEND_LT: begin res0 = mk(TK_LT, 8'h00, 1'b1); cnt = 2'd1; end
                        PEND_GT: begin res0 = mk(TK_GT, 8'h00, 1'b1); cnt = 2'd1; end
                        PEND_EQ: begin res0 = mk(TK_EQ, 8'h00, 1'b1); cnt = 2'd1; end
                        PEND_OR, PEND_AND: begin
                            res0 = mk(TK_ERROR, 8'h00, 1'b1);
                            cnt  = 2'd1;
                        end
                        default: ;
                    endcase
                end
            end
            n_held = 8'h00;
            n_hv   = 1'b0;
            n_pend = PEND_NONE;
            n_err  = 1'b0;
        end else if (!r_err) begin
            if (r_hv) begin
                if (b_id) begin
                    res0   = mk(TK_IDENT, r_held, 1'b0);
                    cnt    = 2'd1;
                    n_held = b;
                end else begin
                    res0   = mk(TK_IDENT, r_held, 1'b1);
                    cnt    = 2'd1;
                    n_hv   = 1'b0;
                    n_held = 8'h00;
                    if (b_single) begin
                        res1 = mk(single_kind(b), 8'h00, 1'b1);
                        cnt  = 2'd2;
                    end
                    n_pend = pend_code(b);
                end
            end else if (r_pend != PEND_NONE) begin
                case (r_pend)
                    PEND_LT: pair = (b == CH_EQ) ? TK_LE : ((b == CH_MINUS) ? TK_ARROW : TK_IDENT);
                    PEND_GT: pair = (b == CH_EQ) ? TK_GE : TK_IDENT;
                    PEND_EQ: pair = (b == CH_EQ) ? TK_EQEQ : TK_IDENT;
                    PEND_OR: pair = (b == CH_BAR) ? TK_OROR : TK_IDENT;
                    PEND_AND: pair = (b == CH_AMP) ? TK_ANDAND : TK_IDENT;
                    default: pair = TK_IDENT;
                endcase
                n_pend = PEND_NONE;
                cnt    = 2'd1;
                if (pair != TK_IDENT) begin
                    res0 = mk(pair, 8'h00, 1'b1);
                end else if (r_pend == PEND_OR || r_pend == PEND_AND) begin
                    res0  = mk(TK_ERROR, 8'h00, 1'b1);
                    n_err = 1'b1;
                end else begin
                    case (r_pend)
                        PEND_LT: res0 = mk(TK_LT, 8'h00, 1'b1);
                        PEND_GT: res0 = mk(TK_GT, 8'h00, 1'b1);
                        default: res0 = mk(TK_EQ, 8'h00, 1'b1);
                    endcase
                    // re-lex the byte as fresh
                    if (b_id) begin
                        n_held = b;
                        n_hv   = 1'b1;
                    end else if (b_single) begin
                        res1 = mk(single_kind(b), 8'h00, 1'b1);
                        cnt  = 2'd2;
                    end else begin
                        n_pend = pend_code(b);
                    end
                end
            end else begin
                if (b_id) begin
                    n_held = b;
                    n_hv   = 1'b1;
                end else if (b_single) begin
                    res0 = mk(single_kind(b), 8'h00, 1'b1);
                    cnt  = 2'd1;
                end
                n_pend = pend_code(b);
            end
        end

        if (cnt == 2'd2) begin
            res1.run_last = 1'b1;
        end else begin
            res0.run_last = 1'b1;
        end
    end

    assign o_push        = i_accept && (cnt != 2'd0);
    assign o_entry.res0  = res0;
    assign o_entry.res1  = res1;
    assign o_entry.two   = (cnt == 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 8'h00;
            r_hv   <= 1'b0;
            r_pend <= PEND_NONE;
            r_err  <= 1'b0;
        end else if (i_accept) begin
            r_held <= n_held;
            r_hv   <= n_hv;
            r_pend <= n_pend;
            r_err  <= n_err;
        end
    end

endmodule

// ===== rtl/qol_fifo.sv =====
// small queue of result entries between the front end and the back end
// depends on qol_pkg
module qol_fifo import qol_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_wdata,
    input  logic   i_pop,
    output t_entry o_rdata,
    output logic   o_empty,
    output logic   o_full
);

    t_entry           r_mem [QDepth];
    t_entry           r_rdata;
    logic [QPtrW-1:0] r_wp, r_rp, n_rp;
    logic [QPtrW:0]   r_cnt, n_cnt;

    assign o_rdata = r_rdata;
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (QPtrW + 1)'(QDepth));

    always_comb begin
        n_cnt = r_cnt;
        n_rp  = i_pop ? r_rp + 1'b1 : r_rp;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    // registered head entry; a push into the slot that becomes the head goes straight through
    always_ff @(posedge i_clk) begin
        if (i_push && (r_wp == n_rp)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[n_rp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== rtl/qol_back.sv =====
// back end: unpacks queued entries into single results behind an output register
// depends on qol_pkg
module qol_back import qol_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_entry i_entry,
    input  logic   i_empty,
    output logic   o_pop,
    input  logic   i_out_stall,
    output logic   o_out_valid,
    output t_out   o_out
);

    logic r_valid, n_valid;
    t_out r_data, n_data;
    logic r_half, n_half;
    logic load;

    always_comb begin
        load    = !r_valid || !i_out_stall;
        n_valid = r_valid && i_out_stall;
        n_data  = r_data;
        n_half  = r_half;
        o_pop   = 1'b0;
        if (load && !i_empty) begin
            n_valid = 1'b1;
            n_data  = r_half ? i_entry.res1 : i_entry.res0;
            if (r_half || !i_entry.two) begin
                o_pop  = 1'b1;
                n_half = 1'b0;
            end else begin
                n_half = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_half  <= n_half;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_out_valid = r_valid;
    assign o_out       = r_data;

endmodule

// ===== rtl/query_operator_lexer.sv =====
// top level of the query operator lexer: front end, result queue, back end
// depends on qol_pkg, qol_front, qol_fifo, qol_back and query_operator_lexer_defines.svh
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-------------------------------
//   in      | input     | i_in_valid / o_in_stall  | i_in  (kind, text_byte)
//   out     | output    | o_out_valid / i_out_stall| o_out (token_kind, ident_char,
//           |           |                          |        token_end, run_last)
//
// one byte is taken per cycle while o_in_stall is low; its first result passes through the queue
// head register and then the output register before it is valid on o_out
// a byte that yields two results occupies the output for both of them; the four-entry queue
// between front and back absorbs that, and o_in_stall rises only when the queue is full
// reset is synchronous active low and clears lexer state, queue pointers and output valid
// i_out_stall holds the output register; the queue keeps filling until it is full
`include "query_operator_lexer_defines.svh"

module query_operator_lexer import qol_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    logic   accept;
    logic   push;
    t_entry wentry;
    t_entry rentry;
    logic   pop;
    logic   empty;
    logic   full;

    // input transaction completes whenever the queue has room
    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    // front end: lexer state and result forming, one byte per cycle while the queue has room
    qol_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_in     (i_in),
        .o_push   (push),
        .o_entry  (wentry)
    );

    // queue decouples byte intake from result delivery
    qol_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (wentry),
        .i_pop   (pop),
        .o_rdata (rentry),
        .o_empty (empty),
        .o_full  (full)
    );

    // back end: one result per output transaction
    qol_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_entry     (rentry),
        .i_empty     (empty),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    // queue never written while full, never read while empty
    `QOL_ASSERT_NOW(a_no_overflow, push, !full, "queue push while full")
    `QOL_ASSERT_NOW(a_no_underflow, pop, !empty, "queue pop while empty")
    // operators and errors always close their token and carry no character
    `QOL_ASSERT_NOW(a_op_shape, o_out_valid && (o_out.token_kind != TK_IDENT),
        o_out.token_end && (o_out.ident_char == 8'h00), "malformed operator result")
    // a popped two-result entry was fully delivered: next output is the run end
    `QOL_ASSERT_NEXT(a_pop_last, pop, o_out_valid && o_out.run_last,
        "entry popped before its last result")

endmodule
